/* rtl/core/magnetic_field_particle_push_macros.svh */
// assertion macros for the particle push rtl
`ifndef MAGNETIC_FIELD_PARTICLE_PUSH_MACROS_SVH
`define MAGNETIC_FIELD_PARTICLE_PUSH_MACROS_SVH

// same-cycle implication, checked outside reset
`define MFPP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("particle push check failed");

// next-cycle implication, checked outside reset
`define MFPP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("particle push check failed");

`endif

/* rtl/core/mfpp_pkg.sv */
// types and saturating fixed-point helpers for the particle push
package mfpp_pkg;
	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int UREG_W = 31;
	localparam int IDX_W  = 3;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [UREG_W-1:0] ureg_t;

	typedef enum logic [IDX_W-1:0] {
		REG_FIELD_X     = 3'd0,
		REG_FIELD_Y     = 3'd1,
		REG_FIELD_Z     = 3'd2,
		REG_STEP        = 3'd3,
		REG_CHARGE_SCL  = 3'd4,
		REG_HALF_FORCE  = 3'd5,
		REG_MAX_ROT     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		word_t tx;
		word_t ty;
		word_t tz;
		word_t energy;
	} trq_t;

	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam ureg_t CHARGE_SCL_RST = ureg_t'(65536);
	localparam ureg_t MAX_ROT_RST = ureg_t'(412);

	function automatic logic [WORD_W-1:0] magw(word_t a);
		return a[WORD_W-1] ? (~a + 1'b1) : a;
	endfunction

	function automatic word_t uext(ureg_t a);
		return word_t'({1'b0, a});
	endfunction

	// sign-magnitude product, magnitude truncated, then saturated
	function automatic word_t smul(word_t a, word_t b);
		logic [WORD_W-1:0] ma;
		logic [WORD_W-1:0] mb;
		logic [2*WORD_W-1:0] p;
		logic [2*WORD_W-FRAC_W-1:0] r;
		logic [2*WORD_W-FRAC_W-1:0] lim;
		logic neg;
		ma = magw(a);
		mb = magw(b);
		neg = a[WORD_W-1] ^ b[WORD_W-1];
		p = ma * mb;
		r = p[2*WORD_W-1:FRAC_W];
		lim = neg ? {{(WORD_W-FRAC_W){1'b0}}, WORD_MIN} : {{(WORD_W-FRAC_W){1'b0}}, WORD_MAX};
		if (r > lim) begin
			r = lim;
		end
		return neg ? word_t'(~r[WORD_W-1:0] + 1'b1) : word_t'(r[WORD_W-1:0]);
	endfunction

	function automatic word_t sadd(word_t a, word_t b);
		logic [WORD_W:0] s;
		s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) begin
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		end
		return word_t'(s[WORD_W-1:0]);
	endfunction

	function automatic word_t ssub(word_t a, word_t b);
		logic [WORD_W:0] s;
		s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
		if (s[WORD_W] != s[WORD_W-1]) begin
			return s[WORD_W] ? WORD_MIN : WORD_MAX;
		end
		return word_t'(s[WORD_W-1:0]);
	endfunction

	function automatic word_t sneg(word_t a);
		return ssub('0, a);
	endfunction

	// halve the magnitude, keep the sign
	function automatic word_t shalf(word_t a);
		logic [WORD_W-1:0] m;
		m = magw(a) >> 1;
		return a[WORD_W-1] ? word_t'(~m + 1'b1) : word_t'(m);
	endfunction
endpackage

/* rtl/core/mfpp_torque.sv */
// two-stage torque and dipole energy lanes
module mfpp_torque (
	input  logic           clk,
	input  mfpp_pkg::word_t field_x,
	input  mfpp_pkg::word_t field_y,
	input  mfpp_pkg::word_t field_z,
	input  mfpp_pkg::word_t dipole_x,
	input  mfpp_pkg::word_t dipole_y,
	input  mfpp_pkg::word_t dipole_z,
	output mfpp_pkg::trq_t  trq
);
	import mfpp_pkg::*;

	word_t bzmy_s1, bymz_s1, bxmz_s1, bzmx_s1, bymx_s1, bxmy_s1;
	word_t mxbx_s1, myby_s1, mzbz_s1;
	trq_t  trq_s2;

	always_ff @(posedge clk) begin
		bzmy_s1 <= smul(field_z, dipole_y);
		bymz_s1 <= smul(field_y, dipole_z);
		bxmz_s1 <= smul(field_x, dipole_z);
		bzmx_s1 <= smul(field_z, dipole_x);
		bymx_s1 <= smul(field_y, dipole_x);
		bxmy_s1 <= smul(field_x, dipole_y);
		mxbx_s1 <= smul(dipole_x, field_x);
		myby_s1 <= smul(dipole_y, field_y);
		mzbz_s1 <= smul(dipole_z, field_z);
	end

	always_ff @(posedge clk) begin
		trq_s2.tx     <= ssub(bzmy_s1, bymz_s1);
		trq_s2.ty     <= ssub(bxmz_s1, bzmx_s1);
		trq_s2.tz     <= ssub(bymx_s1, bxmy_s1);
		trq_s2.energy <= sneg(sadd(sadd(mxbx_s1, myby_s1), mzbz_s1));
	end

	assign trq = trq_s2;
endmodule

/* rtl/core/magnetic_field_particle_push.sv */
// magnetic field particle push, eight-stage pipeline top level
//
// one word in per cycle: pulse start with the particle fields; busy is never
// raised, so start is taken on every cycle it is high
// every word yields one result word at the end of the pipeline, shown for one
// cycle with done high; throughput is one word per clock
// latency is set by the chain of dependent saturating multiplies: charge
// scale, inverse mass, field, step, half-rotation times velocity, rotation
// times the bracket, then the final sum
// the result side cannot hold off words; results are never held or dropped
// configuration: wr_en, wr_index, wr_data write one register per cycle; the user
// must write registers only when no word is in flight; the block does not enforce it
// reset clears the register file to its defaults and empties the pipeline
// field registers feed the torque lanes directly
module magnetic_field_particle_push (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [mfpp_pkg::IDX_W-1:0] wr_index,
	input  logic [31:0]            wr_data,
	input  logic                   start,
	output logic                   busy,
	input  mfpp_pkg::word_t        charge,
	input  mfpp_pkg::ureg_t        inv_mass,
	input  mfpp_pkg::word_t        old_vel_x,
	input  mfpp_pkg::word_t        old_vel_y,
	input  mfpp_pkg::word_t        old_vel_z,
	input  mfpp_pkg::word_t        force_x,
	input  mfpp_pkg::word_t        force_y,
	input  mfpp_pkg::word_t        force_z,
	input  mfpp_pkg::word_t        dipole_x,
	input  mfpp_pkg::word_t        dipole_y,
	input  mfpp_pkg::word_t        dipole_z,
	output logic                   done,
	output mfpp_pkg::word_t        vel_delta_x,
	output mfpp_pkg::word_t        vel_delta_y,
	output mfpp_pkg::word_t        vel_delta_z,
	output mfpp_pkg::word_t        pos_delta_x,
	output mfpp_pkg::word_t        pos_delta_y,
	output mfpp_pkg::word_t        pos_delta_z,
	output mfpp_pkg::word_t        torque_x,
	output mfpp_pkg::word_t        torque_y,
	output mfpp_pkg::word_t        torque_z,
	output mfpp_pkg::word_t        dipole_energy,
	output logic                   strong_field
);
	import mfpp_pkg::*;
	`include "magnetic_field_particle_push_macros.svh"

	word_t field_x_q, field_y_q, field_z_q;
	ureg_t step_q, kscl_q, hfscl_q, maxrot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_x_q <= '0;
			field_y_q <= '0;
			field_z_q <= '0;
			step_q    <= '0;
			kscl_q    <= CHARGE_SCL_RST;
			hfscl_q   <= '0;
			maxrot_q  <= MAX_ROT_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_FIELD_X:    field_x_q <= word_t'(wr_data);
				REG_FIELD_Y:    field_y_q <= word_t'(wr_data);
				REG_FIELD_Z:    field_z_q <= word_t'(wr_data);
				REG_STEP:       step_q    <= wr_data[UREG_W-1:0];
				REG_CHARGE_SCL: kscl_q    <= wr_data[UREG_W-1:0];
				REG_HALF_FORCE: hfscl_q   <= wr_data[UREG_W-1:0];
				REG_MAX_ROT:    maxrot_q  <= wr_data[UREG_W-1:0];
				default: ;
			endcase
		end
	end

	word_t dt;
	word_t fld [3];
	assign dt = uext(step_q);
	assign fld[0] = field_x_q;
	assign fld[1] = field_y_q;
	assign fld[2] = field_z_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic accept;
	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{accept, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	// torque lanes line up with stage 2
	trq_t trq_s2, trq_s3, trq_s4, trq_s5, trq_s6, trq_s7, trq_s8;
	mfpp_torque u_torque (
		.clk      (clk),
		.field_x  (field_x_q),
		.field_y  (field_y_q),
		.field_z  (field_z_q),
		.dipole_x (dipole_x),
		.dipole_y (dipole_y),
		.dipole_z (dipole_z),
		.trq      (trq_s2)
	);

	// stage 1: charge scale and force scale products
	word_t c0_s1, hf0_s1, im_s1;
	word_t vel_s1 [3];
	word_t frc_s1 [3];
	always_ff @(posedge clk) begin
		c0_s1  <= smul(uext(kscl_q), charge);
		hf0_s1 <= smul(uext(hfscl_q), uext(inv_mass));
		im_s1  <= uext(inv_mass);
		vel_s1[0] <= old_vel_x;
		vel_s1[1] <= old_vel_y;
		vel_s1[2] <= old_vel_z;
		frc_s1[0] <= force_x;
		frc_s1[1] <= force_y;
		frc_s1[2] <= force_z;
	end

	// stage 2: charge over mass, half force factor
	word_t c1_s2, hfm_s2;
	word_t vel_s2 [3];
	word_t frc_s2 [3];
	always_ff @(posedge clk) begin
		c1_s2  <= smul(c0_s1, im_s1);
		hfm_s2 <= shalf(hf0_s1);
		vel_s2 <= vel_s1;
		frc_s2 <= frc_s1;
	end

	// stage 3: per-axis field rate and force kick
	word_t cb_s3 [3];
	word_t hf_s3 [3];
	word_t vel_s3 [3];
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			cb_s3[i] <= smul(c1_s2, fld[i]);
			hf_s3[i] <= smul(hfm_s2, frc_s2[i]);
		end
		vel_s3 <= vel_s2;
	end

	// stage 4: rotation per step and kicked velocity
	word_t rot_s4 [3];
	word_t kv_s4 [3];
	word_t vel_s4 [3];
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rot_s4[i] <= smul(dt, cb_s3[i]);
			kv_s4[i]  <= sadd(vel_s3[i], hf_s3[i]);
		end
		vel_s4 <= vel_s3;
	end

	// stage 5: half rotation products and position factors
	word_t hr [3];
	logic  strong_c;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hr[i] = shalf(rot_s4[i]);
		end
		strong_c = (magw(rot_s4[0]) > {1'b0, maxrot_q}) ||
			(magw(rot_s4[1]) > {1'b0, maxrot_q}) ||
			(magw(rot_s4[2]) > {1'b0, maxrot_q});
	end

	word_t hxvy_s5, hxvz_s5, hyvx_s5, hyvz_s5, hzvx_s5, hzvy_s5;
	word_t g_s5 [3];
	word_t rot_s5 [3];
	word_t kv_s5 [3];
	word_t vel_s5 [3];
	logic  strong_s5;
	always_ff @(posedge clk) begin
		hxvy_s5 <= smul(hr[0], vel_s4[1]);
		hxvz_s5 <= smul(hr[0], vel_s4[2]);
		hyvx_s5 <= smul(hr[1], vel_s4[0]);
		hyvz_s5 <= smul(hr[1], vel_s4[2]);
		hzvx_s5 <= smul(hr[2], vel_s4[0]);
		hzvy_s5 <= smul(hr[2], vel_s4[1]);
		for (int i = 0; i < 3; i++) begin
			g_s5[i] <= smul(dt, hr[i]);
		end
		rot_s5    <= rot_s4;
		kv_s5     <= kv_s4;
		vel_s5    <= vel_s4;
		strong_s5 <= strong_c;
	end

	// stage 6: brackets and position products
	word_t in0y_s6, in0z_s6, in1x_s6, in1z_s6, in2x_s6, in2y_s6;
	word_t gyvz_s6, gzvy_s6, gxvz_s6, gzvx_s6, gxvy_s6, gyvx_s6;
	word_t rot_s6 [3];
	logic  strong_s6;
	always_ff @(posedge clk) begin
		in0y_s6 <= ssub(kv_s5[2], hxvy_s5);
		in0z_s6 <= sadd(kv_s5[1], hxvz_s5);
		in1x_s6 <= sadd(kv_s5[2], hyvx_s5);
		in1z_s6 <= ssub(kv_s5[0], hyvz_s5);
		in2x_s6 <= ssub(kv_s5[1], hzvx_s5);
		in2y_s6 <= sadd(kv_s5[0], hzvy_s5);
		gyvz_s6 <= smul(g_s5[1], vel_s5[2]);
		gzvy_s6 <= smul(g_s5[2], vel_s5[1]);
		gxvz_s6 <= smul(g_s5[0], vel_s5[2]);
		gzvx_s6 <= smul(g_s5[2], vel_s5[0]);
		gxvy_s6 <= smul(g_s5[0], vel_s5[1]);
		gyvx_s6 <= smul(g_s5[1], vel_s5[0]);
		rot_s6    <= rot_s5;
		strong_s6 <= strong_s5;
	end

	// stage 7: rotation terms and position sums
	word_t t0y_s7, t0z_s7, t1x_s7, t1z_s7, t2x_s7, t2y_s7;
	word_t pos_s7 [3];
	logic  strong_s7;
	always_ff @(posedge clk) begin
		t0y_s7 <= smul(rot_s6[0], in0y_s6);
		t0z_s7 <= sneg(smul(rot_s6[0], in0z_s6));
		t1x_s7 <= sneg(smul(rot_s6[1], in1x_s6));
		t1z_s7 <= smul(rot_s6[1], in1z_s6);
		t2x_s7 <= smul(rot_s6[2], in2x_s6);
		t2y_s7 <= sneg(smul(rot_s6[2], in2y_s6));
		pos_s7[0] <= sadd(sneg(gyvz_s6), gzvy_s6);
		pos_s7[1] <= ssub(gxvz_s6, gzvx_s6);
		pos_s7[2] <= sadd(sneg(gxvy_s6), gyvx_s6);
		strong_s7 <= strong_s6;
	end

	// stage 8: output word
	word_t vel_s8 [3];
	word_t pos_s8 [3];
	logic  strong_s8;
	always_ff @(posedge clk) begin
		vel_s8[0] <= sadd(t1x_s7, t2x_s7);
		vel_s8[1] <= sadd(t0y_s7, t2y_s7);
		vel_s8[2] <= sadd(t0z_s7, t1z_s7);
		pos_s8    <= pos_s7;
		strong_s8 <= strong_s7;
	end

	always_ff @(posedge clk) begin
		trq_s3 <= trq_s2;
		trq_s4 <= trq_s3;
		trq_s5 <= trq_s4;
		trq_s6 <= trq_s5;
		trq_s7 <= trq_s6;
		trq_s8 <= trq_s7;
	end

	assign done          = v_s8;
	assign vel_delta_x   = vel_s8[0];
	assign vel_delta_y   = vel_s8[1];
	assign vel_delta_z   = vel_s8[2];
	assign pos_delta_x   = pos_s8[0];
	assign pos_delta_y   = pos_s8[1];
	assign pos_delta_z   = pos_s8[2];
	assign torque_x      = trq_s8.tx;
	assign torque_y      = trq_s8.ty;
	assign torque_z      = trq_s8.tz;
	assign dipole_energy = trq_s8.energy;
	assign strong_field  = strong_s8;

	`MFPP_ASSERT_NEXT(a_accept_enters, accept, v_s1)
	`MFPP_ASSERT_NEXT(a_last_stage_done, v_s7, done)
	`MFPP_ASSERT_NOW(a_done_has_source, done, $past(v_s7))
endmodule

/* tb/tb_magnetic_field_particle_push.sv */
// self-checking testbench for the magnetic field particle push
`timescale 1ns / 100ps

module tb_magnetic_field_particle_push;
	import mfpp_pkg::*;

	localparam int STOP_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		word_t q;
		ureg_t im;
		word_t vx, vy, vz;
		word_t fx, fy, fz;
		word_t mx, my, mz;
	} particle_t;

	typedef struct packed {
		word_t dvx, dvy, dvz;
		word_t dpx, dpy, dpz;
		word_t tx, ty, tz;
		word_t energy;
		logic strong_hit;
	} push_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [31:0] wr_data;
	logic start;
	logic busy;
	particle_t drv;
	logic done;
	push_t got;

	// register shadow
	word_t b_x, b_y, b_z;
	ureg_t dt_r, kscale_r, hforce_r, maxrot_r;

	push_t pending_pushes[$];
	int mismatches;
	int n_results;
	longint cycles;
	int burst_left;

	magnetic_field_particle_push dut (
		.clk(clk), .arst_n(arst_n),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.start(start), .busy(busy),
		.charge(drv.q), .inv_mass(drv.im),
		.old_vel_x(drv.vx), .old_vel_y(drv.vy), .old_vel_z(drv.vz),
		.force_x(drv.fx), .force_y(drv.fy), .force_z(drv.fz),
		.dipole_x(drv.mx), .dipole_y(drv.my), .dipole_z(drv.mz),
		.done(done),
		.vel_delta_x(got.dvx), .vel_delta_y(got.dvy), .vel_delta_z(got.dvz),
		.pos_delta_x(got.dpx), .pos_delta_y(got.dpy), .pos_delta_z(got.dpz),
		.torque_x(got.tx), .torque_y(got.ty), .torque_z(got.tz),
		.dipole_energy(got.energy), .strong_field(got.strong_hit)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// fixed-point arithmetic in 64-bit signed, saturating to the word
	function automatic longint sat(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fmul(longint a, longint b);
		logic [63:0] ma, mb;
		logic [127:0] p;
		logic [127:0] r;
		bit neg;
		neg = (a < 0) != (b < 0);
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		p = {64'd0, ma} * {64'd0, mb};
		r = p >> FRAC_W;
		if (neg) begin
			if (r > 128'd2147483648)
				r = 128'd2147483648;
			return -longint'(r[63:0]);
		end
		if (r > 128'd2147483647)
			r = 128'd2147483647;
		return longint'(r[63:0]);
	endfunction

	function automatic longint fhalf(longint a);
		return (a < 0) ? -((-a) >>> 1) : (a >>> 1);
	endfunction

	function automatic longint fabs(longint a);
		return (a < 0) ? -a : a;
	endfunction

	function automatic push_t predict_push(particle_t p);
		push_t r;
		longint bx, by, bz, dt, q, im, vx, vy, vz, fx, fy, fz, mx, my, mz;
		longint c1, rx, ry, rz, hx, hy, hz, gx, gy, gz, hfm, hfx, hfy, hfz;
		longint t0y, t0z, t1x, t1z, t2x, t2y;
		bx = b_x; by = b_y; bz = b_z; dt = dt_r;
		q = p.q; im = p.im;
		vx = p.vx; vy = p.vy; vz = p.vz;
		fx = p.fx; fy = p.fy; fz = p.fz;
		mx = p.mx; my = p.my; mz = p.mz;
		c1 = fmul(fmul(kscale_r, q), im);
		rx = fmul(dt, fmul(c1, bx));
		ry = fmul(dt, fmul(c1, by));
		rz = fmul(dt, fmul(c1, bz));
		hx = fhalf(rx); hy = fhalf(ry); hz = fhalf(rz);
		gx = fmul(dt, hx); gy = fmul(dt, hy); gz = fmul(dt, hz);
		hfm = fhalf(fmul(hforce_r, im));
		hfx = fmul(hfm, fx); hfy = fmul(hfm, fy); hfz = fmul(hfm, fz);
		r.strong_hit = fabs(rx) > maxrot_r || fabs(ry) > maxrot_r || fabs(rz) > maxrot_r;
		t0y = fmul(rx, sat(sat(vz + hfz) - fmul(hx, vy)));
		t0z = sat(-fmul(rx, sat(sat(vy + hfy) + fmul(hx, vz))));
		t1x = sat(-fmul(ry, sat(sat(vz + hfz) + fmul(hy, vx))));
		t1z = fmul(ry, sat(sat(vx + hfx) - fmul(hy, vz)));
		t2x = fmul(rz, sat(sat(vy + hfy) - fmul(hz, vx)));
		t2y = sat(-fmul(rz, sat(sat(vx + hfx) + fmul(hz, vy))));
		r.dvx = word_t'(sat(t1x + t2x));
		r.dvy = word_t'(sat(t0y + t2y));
		r.dvz = word_t'(sat(t0z + t1z));
		r.dpx = word_t'(sat(sat(-fmul(gy, vz)) + fmul(gz, vy)));
		r.dpy = word_t'(sat(fmul(gx, vz) - fmul(gz, vx)));
		r.dpz = word_t'(sat(sat(-fmul(gx, vy)) + fmul(gy, vx)));
		r.tx = word_t'(sat(fmul(bz, my) - fmul(by, mz)));
		r.ty = word_t'(sat(fmul(bx, mz) - fmul(bz, mx)));
		r.tz = word_t'(sat(fmul(by, mx) - fmul(bx, my)));
		r.energy = word_t'(sat(-sat(sat(fmul(mx, bx) + fmul(my, by)) + fmul(mz, bz))));
		return r;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			REG_FIELD_X: b_x = val;
			REG_FIELD_Y: b_y = val;
			REG_FIELD_Z: b_z = val;
			REG_STEP: dt_r = val[30:0];
			REG_CHARGE_SCL: kscale_r = val[30:0];
			REG_HALF_FORCE: hforce_r = val[30:0];
			REG_MAX_ROT: maxrot_r = val[30:0];
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	// drops start on the edge that takes the last word, then drains
	task automatic wait_idle();
		@(posedge clk);
		start <= 1'b0;
		while (pending_pushes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// drives one word; returns just before the edge that takes it
	task automatic send_particle(particle_t p, bit allow_gap);
		if (allow_gap) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 30);
				if ($urandom_range(0, 2) != 0) begin
					@(posedge clk);
					start <= 1'b0;
					repeat ($urandom_range(0, 5)) @(posedge clk);
				end
			end
			burst_left--;
		end
		@(posedge clk);
		start <= 1'b1;
		drv <= p;
		pending_pushes.push_back(predict_push(p));
		@(negedge clk);
		while (busy)
			@(negedge clk);
	endtask

	function automatic word_t rand_word(int mode);
		case (mode)
			0: return word_t'($urandom());
			1: return word_t'($signed($urandom_range(0, 262143)) - 131072);
			2: return $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
			default: return word_t'($signed($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	function automatic particle_t rand_particle();
		particle_t p;
		int m;
		m = $urandom_range(0, 3);
		p.q = rand_word(m);
		p.im = ($urandom_range(0, 3) == 0) ? ureg_t'($urandom()) :
			ureg_t'($urandom_range(0, 262143));
		p.vx = rand_word($urandom_range(0, 3));
		p.vy = rand_word($urandom_range(0, 3));
		p.vz = rand_word($urandom_range(0, 3));
		p.fx = rand_word($urandom_range(0, 3));
		p.fy = rand_word($urandom_range(0, 3));
		p.fz = rand_word($urandom_range(0, 3));
		p.mx = rand_word($urandom_range(0, 3));
		p.my = rand_word($urandom_range(0, 3));
		p.mz = rand_word($urandom_range(0, 3));
		return p;
	endfunction

	task automatic test_reset_defaults();
		particle_t p;
		p = '0;
		p.q = 32'sh0001_0000;
		p.im = 31'h0001_0000;
		p.vx = 32'sh0002_0000;
		send_particle(p, 1'b0);
		wait_idle();
	endtask

	task automatic test_extremes();
		particle_t p;
		write_reg(REG_FIELD_X, 32'h7fff_ffff);
		write_reg(REG_FIELD_Y, 32'h8000_0000);
		write_reg(REG_FIELD_Z, 32'h0001_8000);
		write_reg(REG_STEP, 32'h7fff_ffff);
		write_reg(REG_CHARGE_SCL, 32'h0001_0000);
		write_reg(REG_HALF_FORCE, 32'h7fff_ffff);
		write_reg(REG_MAX_ROT, 32'h0);
		p = '1;
		send_particle(p, 1'b0);
		p = '0;
		send_particle(p, 1'b0);
		p = {WORD_MIN, 31'h7fff_ffff, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX,
			WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN};
		send_particle(p, 1'b0);
		p = {WORD_MAX, 31'h0, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
			WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX};
		send_particle(p, 1'b0);
		wait_idle();
		// zero charge, zero inverse mass and zero field
		write_reg(REG_STEP, 32'h0000_0100);
		write_reg(REG_MAX_ROT, 32'h7fff_ffff);
		p = rand_particle();
		p.q = '0;
		send_particle(p, 1'b0);
		p = rand_particle();
		p.im = '0;
		send_particle(p, 1'b0);
		wait_idle();
		write_reg(REG_FIELD_X, 32'h0);
		write_reg(REG_FIELD_Y, 32'h0);
		write_reg(REG_FIELD_Z, 32'h0);
		send_particle(rand_particle(), 1'b0);
		wait_idle();
		// out of range index is ignored
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= 3'd7;
		wr_data <= 32'hffff_ffff;
		@(posedge clk);
		wr_en <= 1'b0;
		send_particle(rand_particle(), 1'b0);
		wait_idle();
	endtask

	task automatic test_random_phases(int phases, int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			write_reg(REG_FIELD_X, (ph % 3 == 0) ? $urandom() : $urandom_range(0, 131071) - 65536);
			write_reg(REG_FIELD_Y, (ph % 4 == 1) ? $urandom() : $urandom_range(0, 131071) - 65536);
			write_reg(REG_FIELD_Z, (ph % 5 == 2) ? $urandom() : $urandom_range(0, 131071) - 65536);
			write_reg(REG_STEP, (ph % 3 == 1) ? $urandom() : $urandom_range(0, 65536));
			write_reg(REG_CHARGE_SCL, (ph % 4 == 3) ? $urandom() : $urandom_range(0, 131072));
			write_reg(REG_HALF_FORCE, (ph % 2 == 0) ? $urandom() : $urandom_range(0, 65536));
			write_reg(REG_MAX_ROT, (ph % 3 == 2) ? $urandom() : $urandom_range(0, 2000));
			for (int i = 0; i < per_phase; i++)
				send_particle(rand_particle(), 1'b1);
			wait_idle();
		end
	endtask

	// result checker
	always @(posedge clk) begin
		push_t want;
		if (arst_n)
			cycles <= cycles + 1;
		if (arst_n && done) begin
			n_results <= n_results + 1;
			if (pending_pushes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", got);
			end else begin
				want = pending_pushes.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch on result %0d", n_results);
						$display("  vel  exp %h %h %h got %h %h %h",
							want.dvx, want.dvy, want.dvz, got.dvx, got.dvy, got.dvz);
						$display("  pos  exp %h %h %h got %h %h %h",
							want.dpx, want.dpy, want.dpz, got.dpx, got.dpy, got.dpz);
						$display("  trq  exp %h %h %h got %h %h %h",
							want.tx, want.ty, want.tz, got.tx, got.ty, got.tz);
						$display("  enrg exp %h got %h  strong exp %b got %b",
							want.energy, got.energy, want.strong_hit, got.strong_hit);
					end
				end
			end
		end
	end

	initial begin
		wait (cycles > STOP_CYCLES);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		start = 1'b0;
		drv = '0;
		mismatches = 0;
		n_results = 0;
		cycles = 0;
		burst_left = 0;
		b_x = '0; b_y = '0; b_z = '0;
		dt_r = '0;
		kscale_r = CHARGE_SCL_RST;
		hforce_r = '0;
		maxrot_r = MAX_ROT_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_extremes();
		test_random_phases(12, 150);
		wait_idle();
		if (mismatches == 0 && pending_pushes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
